// ===== rtl/dbcr_pkg.sv =====
// ----------------------------------------------------------------------------
// dbcr_pkg
// shared types, constants and curve tables for the backlight curve/ramp unit
// ----------------------------------------------------------------------------
package dbcr_pkg;

  localparam int PCT_W    = 7;
  localparam int MIN_W    = 11;
  localparam int ANC_W    = 13;
  localparam int DIFF_W   = ANC_W + 1;
  localparam int SPAN_W   = 12;
  localparam int ACC_W    = SPAN_W + PCT_W - 1;
  localparam int UP_W     = 32;
  localparam int END_W    = UP_W + 1;
  localparam int HM_W     = 6;
  localparam int SECS_W   = 12;
  localparam int IDX_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [MIN_W-1:0] FALLBACK_RISE = 11'd390;
  localparam logic [MIN_W-1:0] FALLBACK_SET  = 11'd1170;
  localparam logic [PCT_W-1:0] PCT_FULL      = 7'd100;
  localparam logic [PCT_W-1:0] LEVEL_RESET   = 7'd100;
  localparam logic [PCT_W-1:0] MIN_RESET     = 7'd5;
  localparam logic [PCT_W-1:0] MAX_RESET     = 7'd100;
  localparam logic [HM_W-1:0]  HOLD_RESET    = 6'd10;
  localparam logic [HM_W-1:0]  HOLD_LO       = 6'd1;
  localparam logic [HM_W-1:0]  HOLD_HI       = 6'd60;
  localparam logic [IDX_W-1:0] ANC_FIRST     = 3'd1;
  localparam logic [IDX_W-1:0] ANC_LAST      = 3'd6;

  typedef enum logic [1:0] {
    KIND_EVAL = 2'd0,
    KIND_TICK = 2'd1,
    KIND_OVR  = 2'd2,
    KIND_RSVD = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLED = 2'd0,
    CFG_MIN_PCT = 2'd1,
    CFG_MAX_PCT = 2'd2,
    CFG_HOLD    = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_INTERP,
    ST_CLAMP,
    ST_OUT
  } top_state_t;

  typedef enum logic [1:0] {
    IP_IDLE,
    IP_MUL,
    IP_DIV,
    IP_DONE
  } interp_state_t;

  typedef struct packed {
    logic              start;
    logic [PCT_W-1:0]  p_lo;
    logic [PCT_W-1:0]  p_hi;
    logic [SPAN_W-1:0] span;
    logic [SPAN_W-1:0] num;
  } interp_cmd_t;

  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] quot;
  } interp_sts_t;

  // percent at each curve anchor
  function automatic logic [PCT_W-1:0] anchor_pct(logic [IDX_W-1:0] idx);
    logic [PCT_W-1:0] p;
    unique case (idx)
      3'd2, 3'd5: p = 7'd60;
      3'd3, 3'd4: p = 7'd100;
      default:    p = 7'd5;
    endcase
    return p;
  endfunction

  // minute of each curve anchor, signed
  function automatic logic signed [ANC_W-1:0] anchor_min(
    logic [IDX_W-1:0] idx,
    logic [MIN_W-1:0] rise,
    logic [MIN_W-1:0] sset,
    logic [MIN_W-1:0] noon
  );
    logic signed [ANC_W-1:0] r;
    logic signed [ANC_W-1:0] s;
    logic signed [ANC_W-1:0] n;
    logic signed [ANC_W-1:0] a;
    r = signed'({2'b00, rise});
    s = signed'({2'b00, sset});
    n = signed'({2'b00, noon});
    unique case (idx)
      3'd1:    a = r - 13'sd60;
      3'd2:    a = r + 13'sd30;
      3'd3:    a = n - 13'sd120;
      3'd4:    a = n + 13'sd120;
      3'd5:    a = s - 13'sd30;
      default: a = s + 13'sd60;
    endcase
    return a;
  endfunction

  function automatic logic [PCT_W-1:0] sat_pct(logic [PCT_W-1:0] v);
    return (v > PCT_FULL) ? PCT_FULL : v;
  endfunction

endpackage

// ===== rtl/dbcr_interp.sv =====
// ----------------------------------------------------------------------------
// dbcr_interp
// serial interpolation: shift-add weighting then restoring division by span
// ----------------------------------------------------------------------------
module dbcr_interp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dbcr_pkg::interp_cmd_t cmd,
  output dbcr_pkg::interp_sts_t sts
);

  localparam logic [dbcr_pkg::IDX_W-1:0] LAST_STEP = dbcr_pkg::IDX_W'(dbcr_pkg::PCT_W - 1);

  dbcr_pkg::interp_state_t state_r, state_nxt;

  logic [dbcr_pkg::IDX_W-1:0]  cnt_r;
  logic [dbcr_pkg::ACC_W-1:0]  a_r;
  logic [dbcr_pkg::ACC_W-1:0]  b_r;
  logic [dbcr_pkg::PCT_W-1:0]  c0_r;
  logic [dbcr_pkg::PCT_W-1:0]  c1_r;
  logic [dbcr_pkg::ACC_W-1:0]  acc_r;
  logic [dbcr_pkg::ACC_W-1:0]  acc_nxt;
  logic [dbcr_pkg::SPAN_W-1:0] span_r;
  logic [dbcr_pkg::ACC_W-1:0]  dvs_r;
  logic [dbcr_pkg::PCT_W-1:0]  q_r;
  logic                        ge;
  logic                        last;

  assign acc_nxt = acc_r + (c0_r[0] ? a_r : '0) + (c1_r[0] ? b_r : '0);
  assign ge      = acc_r >= dvs_r;
  assign last    = cnt_r == LAST_STEP;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dbcr_pkg::IP_IDLE: if (cmd.start) state_nxt = dbcr_pkg::IP_MUL;
      dbcr_pkg::IP_MUL:  if (last) state_nxt = dbcr_pkg::IP_DIV;
      dbcr_pkg::IP_DIV:  if (last) state_nxt = dbcr_pkg::IP_DONE;
      dbcr_pkg::IP_DONE: state_nxt = dbcr_pkg::IP_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    sts.done = state_r == dbcr_pkg::IP_DONE;
    sts.quot = q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dbcr_pkg::IP_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == dbcr_pkg::IP_IDLE || last) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      dbcr_pkg::IP_IDLE: begin
        a_r    <= dbcr_pkg::ACC_W'(cmd.span - cmd.num);
        b_r    <= dbcr_pkg::ACC_W'(cmd.num);
        c0_r   <= cmd.p_lo;
        c1_r   <= cmd.p_hi;
        span_r <= cmd.span;
        acc_r  <= '0;
      end
      dbcr_pkg::IP_MUL: begin
        acc_r <= acc_nxt;
        a_r   <= a_r << 1;
        b_r   <= b_r << 1;
        c0_r  <= c0_r >> 1;
        c1_r  <= c1_r >> 1;
        dvs_r <= {span_r, (dbcr_pkg::PCT_W - 1)'(0)};
        q_r   <= '0;
      end
      dbcr_pkg::IP_DIV: begin
        if (ge) begin
          acc_r <= acc_r - dvs_r;
        end
        q_r   <= {q_r[dbcr_pkg::PCT_W-2:0], ge};
        dvs_r <= dvs_r >> 1;
      end
      dbcr_pkg::IP_DONE: begin
        acc_r <= acc_r;
      end
    endcase
  end

endmodule

// ===== rtl/daylight_backlight_curve_ramp_unit.sv =====
// ----------------------------------------------------------------------------
// daylight_backlight_curve_ramp_unit
// backlight auto-brightness: daylight curve target, ramp ticks, override hold
// ----------------------------------------------------------------------------
//  channel | dir | ports                                         | handshake
//  in      | in  | kind, now/sunrise/sunset min, sun_valid, ...  | in_valid/in_ready
//  out     | out | level_pct, target_pct, holding, level_changed | out_valid/out_ready
//  cfg     | in  | cfg_index, cfg_data                           | cfg_valid/cfg_ready
//
//  tick, override and ignored requests: go straight to the output state
//  evaluate: anchor search, then (when needed) shift-add, divide and finish
//  steps in the serial interpolator, then the clamp and output states
//  one request in flight; in_ready returns once the result sits in the output
//  register, the next result waits in ST_OUT until the output register is free
//  reset is synchronous; cfg_ready is always high
// ----------------------------------------------------------------------------
module daylight_backlight_curve_ramp_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_kind,
  input  logic [dbcr_pkg::MIN_W-1:0]        in_now_min,
  input  logic [dbcr_pkg::MIN_W-1:0]        in_sunrise_min,
  input  logic [dbcr_pkg::MIN_W-1:0]        in_sunset_min,
  input  logic                              in_sun_valid,
  input  logic [dbcr_pkg::UP_W-1:0]         in_uptime_s,
  input  logic [dbcr_pkg::PCT_W-1:0]        in_override_pct,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dbcr_pkg::PCT_W-1:0]        out_level_pct,
  output logic [dbcr_pkg::PCT_W-1:0]        out_target_pct,
  output logic                              out_holding,
  output logic                              out_level_changed,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dbcr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dbcr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  dbcr_pkg::top_state_t state_r, state_nxt;

  logic                              enabled_r;
  logic [dbcr_pkg::PCT_W-1:0]        min_r;
  logic [dbcr_pkg::PCT_W-1:0]        max_r;
  logic [dbcr_pkg::HM_W-1:0]         hold_min_r;
  logic [dbcr_pkg::PCT_W-1:0]        level_r;
  logic [dbcr_pkg::PCT_W-1:0]        target_r;
  logic                              hold_r;
  logic [dbcr_pkg::END_W-1:0]        hold_end_r;
  logic                              changed_r;
  logic [dbcr_pkg::MIN_W-1:0]        now_r;
  logic [dbcr_pkg::MIN_W-1:0]        rise_r;
  logic [dbcr_pkg::MIN_W-1:0]        set_r;
  logic [dbcr_pkg::MIN_W-1:0]        noon_r;
  logic [dbcr_pkg::IDX_W-1:0]        idx_r;
  logic signed [dbcr_pkg::ANC_W-1:0] a_prev_r;
  logic [dbcr_pkg::PCT_W-1:0]        raw_r;
  logic                              out_valid_r;
  logic [dbcr_pkg::PCT_W-1:0]        out_level_r;
  logic [dbcr_pkg::PCT_W-1:0]        out_target_r;
  logic                              out_hold_r;
  logic                              out_changed_r;

  logic                              in_fire;
  logic                              cfg_fire;
  dbcr_pkg::kind_t                   kind;
  logic                              hold_block;
  logic                              eval_go;
  logic [dbcr_pkg::MIN_W-1:0]        sel_rise;
  logic [dbcr_pkg::MIN_W-1:0]        sel_set;
  logic [dbcr_pkg::MIN_W:0]          rs_sum;
  logic [dbcr_pkg::HM_W-1:0]         hm;
  logic [dbcr_pkg::SECS_W-1:0]       hold_secs;
  logic signed [dbcr_pkg::ANC_W-1:0] a_cur;
  logic signed [dbcr_pkg::ANC_W-1:0] now_s;
  logic signed [dbcr_pkg::DIFF_W-1:0] span_s;
  logic signed [dbcr_pkg::DIFF_W-1:0] num_s;
  logic                              hit;
  logic                              search_done;
  logic                              need_interp;
  logic [dbcr_pkg::PCT_W-1:0]        raw_pick;
  logic [dbcr_pkg::PCT_W-1:0]        lo_pct;
  logic [dbcr_pkg::PCT_W-1:0]        hi_pct;
  logic [dbcr_pkg::PCT_W-1:0]        clamp_val;
  logic                              out_load;
  dbcr_pkg::interp_cmd_t             icmd;
  dbcr_pkg::interp_sts_t             ists;

  assign in_fire  = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire = cfg_valid && cfg_ready;
  assign kind     = dbcr_pkg::kind_t'(in_kind);

  assign hold_block = hold_r && ({1'b0, in_uptime_s} < hold_end_r);
  assign eval_go    = in_fire && enabled_r && (kind == dbcr_pkg::KIND_EVAL) && !hold_block;

  assign sel_rise = in_sun_valid ? in_sunrise_min : dbcr_pkg::FALLBACK_RISE;
  assign sel_set  = in_sun_valid ? in_sunset_min  : dbcr_pkg::FALLBACK_SET;
  assign rs_sum   = {1'b0, sel_rise} + {1'b0, sel_set};

  always_comb begin
    priority if (hold_min_r < dbcr_pkg::HOLD_LO) begin
      hm = dbcr_pkg::HOLD_LO;
    end else if (hold_min_r > dbcr_pkg::HOLD_HI) begin
      hm = dbcr_pkg::HOLD_HI;
    end else begin
      hm = hold_min_r;
    end
  end
  // minutes times sixty
  assign hold_secs = {hm, 6'b0} - dbcr_pkg::SECS_W'({hm, 2'b0});

  // anchor search, one anchor per cycle
  assign a_cur  = dbcr_pkg::anchor_min(idx_r, rise_r, set_r, noon_r);
  assign now_s  = signed'({2'b00, now_r});
  assign hit    = now_s <= a_cur;
  assign span_s = {a_cur[dbcr_pkg::ANC_W-1], a_cur} - {a_prev_r[dbcr_pkg::ANC_W-1], a_prev_r};
  assign num_s  = {now_s[dbcr_pkg::ANC_W-1], now_s} - {a_prev_r[dbcr_pkg::ANC_W-1], a_prev_r};
  assign search_done = hit || (idx_r == dbcr_pkg::ANC_LAST);
  assign need_interp = hit && (idx_r != dbcr_pkg::ANC_FIRST) && (span_s > 0) && (num_s > 0);

  always_comb begin
    priority if (!hit) begin
      raw_pick = dbcr_pkg::anchor_pct(dbcr_pkg::ANC_LAST);
    end else if (idx_r == dbcr_pkg::ANC_FIRST) begin
      raw_pick = dbcr_pkg::anchor_pct('0);
    end else if (span_s <= 0) begin
      raw_pick = dbcr_pkg::anchor_pct(idx_r);
    end else begin
      raw_pick = dbcr_pkg::anchor_pct(idx_r - 1'b1);
    end
  end

  assign lo_pct = dbcr_pkg::sat_pct(min_r);
  assign hi_pct = dbcr_pkg::sat_pct(max_r);
  always_comb begin
    priority if (raw_r < lo_pct) begin
      clamp_val = lo_pct;
    end else if (raw_r > hi_pct) begin
      clamp_val = hi_pct;
    end else begin
      clamp_val = raw_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dbcr_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = eval_go ? dbcr_pkg::ST_SEARCH : dbcr_pkg::ST_OUT;
        end
      end
      dbcr_pkg::ST_SEARCH: begin
        priority if (need_interp) begin
          state_nxt = dbcr_pkg::ST_INTERP;
        end else if (search_done) begin
          state_nxt = dbcr_pkg::ST_CLAMP;
        end
      end
      dbcr_pkg::ST_INTERP: if (ists.done) state_nxt = dbcr_pkg::ST_CLAMP;
      dbcr_pkg::ST_CLAMP:  state_nxt = dbcr_pkg::ST_OUT;
      dbcr_pkg::ST_OUT:    if (out_load) state_nxt = dbcr_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = state_r == dbcr_pkg::ST_IDLE;
    out_load   = (state_r == dbcr_pkg::ST_OUT) && (!out_valid_r || out_ready);
    icmd.start = (state_r == dbcr_pkg::ST_SEARCH) && need_interp;
    icmd.p_lo  = dbcr_pkg::anchor_pct(idx_r - 1'b1);
    icmd.p_hi  = dbcr_pkg::anchor_pct(idx_r);
    icmd.span  = span_s[dbcr_pkg::SPAN_W-1:0];
    icmd.num   = num_s[dbcr_pkg::SPAN_W-1:0];
  end

  dbcr_interp u_interp (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (icmd),
    .sts   (ists)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dbcr_pkg::ST_IDLE;
      enabled_r   <= 1'b0;
      min_r       <= dbcr_pkg::MIN_RESET;
      max_r       <= dbcr_pkg::MAX_RESET;
      hold_min_r  <= dbcr_pkg::HOLD_RESET;
      level_r     <= dbcr_pkg::LEVEL_RESET;
      target_r    <= dbcr_pkg::LEVEL_RESET;
      hold_r      <= 1'b0;
      hold_end_r  <= '0;
      changed_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_fire) begin
        unique case (dbcr_pkg::cfg_idx_t'(cfg_index))
          dbcr_pkg::CFG_ENABLED: enabled_r  <= cfg_data[0];
          dbcr_pkg::CFG_MIN_PCT: min_r      <= cfg_data;
          dbcr_pkg::CFG_MAX_PCT: max_r      <= cfg_data;
          dbcr_pkg::CFG_HOLD:    hold_min_r <= cfg_data[dbcr_pkg::HM_W-1:0];
        endcase
      end

      if (in_fire) begin
        changed_r <= enabled_r && (kind == dbcr_pkg::KIND_TICK) && (level_r != target_r);
        if (enabled_r) begin
          unique case (kind)
            dbcr_pkg::KIND_EVAL: begin
              if (!hold_block) begin
                hold_r <= 1'b0;
              end
            end
            dbcr_pkg::KIND_TICK: begin
              if (level_r != target_r) begin
                level_r <= (level_r < target_r) ? level_r + 1'b1 : level_r - 1'b1;
              end
            end
            dbcr_pkg::KIND_OVR: begin
              hold_r     <= 1'b1;
              hold_end_r <= {1'b0, in_uptime_s} + dbcr_pkg::END_W'(hold_secs);
              level_r    <= dbcr_pkg::sat_pct(in_override_pct);
              target_r   <= dbcr_pkg::sat_pct(in_override_pct);
            end
            dbcr_pkg::KIND_RSVD: begin
              hold_r <= hold_r;
            end
          endcase
        end
      end

      if (state_r == dbcr_pkg::ST_CLAMP) begin
        target_r <= clamp_val;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (eval_go) begin
      now_r    <= in_now_min;
      rise_r   <= sel_rise;
      set_r    <= sel_set;
      noon_r   <= rs_sum[dbcr_pkg::MIN_W:1];
      idx_r    <= dbcr_pkg::ANC_FIRST;
      a_prev_r <= dbcr_pkg::anchor_min('0, sel_rise, sel_set, rs_sum[dbcr_pkg::MIN_W:1]);
    end else if (state_r == dbcr_pkg::ST_SEARCH && !search_done) begin
      idx_r    <= idx_r + 1'b1;
      a_prev_r <= a_cur;
    end

    if (state_r == dbcr_pkg::ST_SEARCH && search_done && !need_interp) begin
      raw_r <= raw_pick;
    end else if (state_r == dbcr_pkg::ST_INTERP && ists.done) begin
      raw_r <= ists.quot;
    end

    if (out_load) begin
      out_level_r   <= level_r;
      out_target_r  <= target_r;
      out_hold_r    <= hold_r;
      out_changed_r <= changed_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_level_pct     = out_level_r;
  assign out_target_pct    = out_target_r;
  assign out_holding       = out_hold_r;
  assign out_level_changed = out_changed_r;

`ifndef ASSERT_OFF
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_level_pct <= dbcr_pkg::PCT_FULL) && (out_target_pct <= dbcr_pkg::PCT_FULL))
    else $error("result percent above full scale");

  a_interp_owner: assert property (@(posedge clk) disable iff (!rst_n)
    ists.done |-> state_r == dbcr_pkg::ST_INTERP)
    else $error("interpolator finished outside interpolation phase");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("second request taken before result was formed");

  a_raw_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dbcr_pkg::ST_CLAMP |-> raw_r <= dbcr_pkg::PCT_FULL)
    else $error("curve value above full scale");
`endif

endmodule
